### hw/rtl/lfrf_pkg.sv
// Shared types and constants for the longest free run finder.
// Standalone package; used by longest_free_run_finder.
package lfrf_pkg;

  // Number of chunk slots a scan may index.
  localparam int unsigned MaxChunks  = 65536;
  localparam int unsigned IdxW       = 16;
  localparam int unsigned LenW       = 17;
  localparam int unsigned IndexLimit = (MaxChunks > (1 << IdxW)) ? (1 << IdxW) : MaxChunks;
  localparam logic [IdxW-1:0] IndexLast = IdxW'(IndexLimit - 1);

  localparam logic [LenW-1:0] MaxRunReset = LenW'(65536);

  // Register map, indexed by word address.
  localparam logic RegMaxRunLength = 1'b0;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] range_first;
    logic [IdxW-1:0] range_last;
  } lfrf_res_t;

endpackage

### hw/rtl/longest_free_run_finder.sv
// Longest free run finder: scans chunk status words and reports a run of
// free chunks. Depends on lfrf_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one chunk status word per
//   chunk, in index order from chunk 0; last_chunk_i closes the scan.
//   Output channel (out_valid_o / out_stall_i) carries at most one result
//   word per scan: either the first run that reaches max_run_length, or at
//   the last chunk the longest run (found_o = 0 with zero range if none).
//   Throughput: one chunk word per cycle while in_stall_o is low. The run and
//   best-run update is a single increment and compare between the state
//   registers and the result register; a result is registered into the output
//   register, or into the skid register while the output holds a waiting word.
//   A two-entry output (result register plus skid register) keeps input
//   flowing while a result waits; in_stall_o rises only when both hold a
//   word the receiver has not taken.
//   Reset clears the scan state, empties the output and sets max_run_length
//   to 65536. Write max_run_length over APB (byte address 0) only while idle.
module longest_free_run_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        chunk_held_i,
  input  logic        web_seed_ok_i,
  input  logic        last_chunk_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [lfrf_pkg::IdxW-1:0] range_first_o,
  output logic [lfrf_pkg::IdxW-1:0] range_last_o
);
  import lfrf_pkg::*;

  logic [LenW-1:0] max_run_q;
  logic [IdxW-1:0] chunk_index_q, chunk_index_d;
  logic            index_full_q, index_full_d;
  logic [IdxW-1:0] run_start_q, run_start_d;
  logic [LenW-1:0] run_length_q, run_length_d;
  logic [IdxW-1:0] best_start_q, best_start_d;
  logic [LenW-1:0] best_length_q, best_length_d;
  logic            reported_q, reported_d;

  lfrf_res_t       out_q, skid_q, res_c;
  logic            out_valid_q, skid_valid_q;
  logic            res_valid_c;

  logic            in_accept, out_fire, cfg_write;
  logic            free_chunk;
  logic [IdxW-1:0] new_start, step_best_start, fin_start, rep_start;
  logic [LenW-1:0] new_length, step_best_length, fin_length, rep_length;
  logic            early;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == RegMaxRunLength);
  assign prdata    = (paddr[2] == RegMaxRunLength) ? {15'b0, max_run_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q <= MaxRunReset;
    end else if (cfg_write) begin
      max_run_q <= pwdata[LenW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Scan step
  // ---------------------------------------------------------------------
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign free_chunk = !chunk_held_i && web_seed_ok_i && !index_full_q;

  always_comb begin
    // Current run after this chunk
    if (run_length_q == '0) begin
      new_start  = chunk_index_q;
      new_length = LenW'(1);
    end else begin
      new_start  = run_start_q;
      new_length = (run_length_q == '1) ? run_length_q : run_length_q + LenW'(1);
    end
    early = free_chunk && (new_length >= max_run_q);

    // Best after closing the run on a busy chunk
    if (!free_chunk && (run_length_q > best_length_q)) begin
      step_best_start  = run_start_q;
      step_best_length = run_length_q;
    end else begin
      step_best_start  = best_start_q;
      step_best_length = best_length_q;
    end

    // Best after the closing pass on the last chunk
    if (free_chunk && (new_length > step_best_length)) begin
      fin_start  = new_start;
      fin_length = new_length;
    end else begin
      fin_start  = step_best_start;
      fin_length = step_best_length;
    end

    rep_start  = early ? new_start : fin_start;
    rep_length = early ? new_length : fin_length;

    res_valid_c       = in_accept && !reported_q && (early || last_chunk_i);
    res_c.found       = early || (fin_length != '0);
    res_c.range_first = res_c.found ? rep_start : '0;
    res_c.range_last  = res_c.found ? IdxW'({1'b0, rep_start} + (rep_length - LenW'(1))) : '0;
  end

  always_comb begin
    chunk_index_d = chunk_index_q;
    index_full_d  = index_full_q;
    run_start_d   = run_start_q;
    run_length_d  = run_length_q;
    best_start_d  = best_start_q;
    best_length_d = best_length_q;
    reported_d    = reported_q;
    if (in_accept) begin
      if (last_chunk_i) begin
        // Start a fresh scan with the next word
        chunk_index_d = '0;
        index_full_d  = 1'b0;
        run_start_d   = '0;
        run_length_d  = '0;
        best_start_d  = '0;
        best_length_d = '0;
        reported_d    = 1'b0;
      end else if (!reported_q) begin
        if (!index_full_q) begin
          if (chunk_index_q == IndexLast) begin
            index_full_d = 1'b1;
          end else begin
            chunk_index_d = chunk_index_q + IdxW'(1);
          end
        end
        if (free_chunk) begin
          run_start_d  = new_start;
          run_length_d = new_length;
        end else begin
          run_start_d  = '0;
          run_length_d = '0;
        end
        best_start_d  = step_best_start;
        best_length_d = step_best_length;
        reported_d    = early;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_index_q <= '0;
      index_full_q  <= 1'b0;
      run_start_q   <= '0;
      run_length_q  <= '0;
      best_start_q  <= '0;
      best_length_q <= '0;
      reported_q    <= 1'b0;
    end else begin
      chunk_index_q <= chunk_index_d;
      index_full_q  <= index_full_d;
      run_start_q   <= run_start_d;
      run_length_q  <= run_length_d;
      best_start_q  <= best_start_d;
      best_length_q <= best_length_d;
      reported_q    <= reported_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register and skid
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= skid_valid_q || res_valid_c;
      end
      if (skid_valid_q) begin
        if (out_fire) skid_valid_q <= 1'b0;
      end else if (res_valid_c && out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_q <= skid_valid_q ? skid_q : res_c;
    end
    if (!skid_valid_q && res_valid_c && out_valid_q && !out_fire) begin
      skid_q <= res_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign range_first_o = out_q.range_first;
  assign range_last_o  = out_q.range_last;

`ifndef NO_ASSERTIONS
  // Skid only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output register is empty");

  // A "none found" result carries a zero range.
  a_none_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (range_first_o == '0 && range_last_o == '0))
    else $error("empty result with nonzero range");

  // The index stops advancing once the last slot has been used.
  a_index_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_full_q |-> (chunk_index_q == IndexLast))
    else $error("chunk index moved past its limit");

  // After an early report no further result comes from this scan.
  a_quiet_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> !res_valid_c)
    else $error("second result in one scan");
`endif

endmodule

### tb/tb_top.sv
// Testbench for longest_free_run_finder: streams chunk status words, predicts
// each scan's run report and checks every result word field by field.
// Depends on lfrf_pkg and the longest_free_run_finder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrf_pkg::*;

  localparam logic [2:0]  MaxRunAddr   = 3'(4 * RegMaxRunLength);
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 213;

  typedef struct {
    bit          set_cap;
    logic [31:0] cap;
    logic        held;
    logic        web;
    logic        is_last;
    bit          typed;
    lfrf_res_t   word;
  } chunk_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            chunk_held_i = 1'b0;
  logic            web_seed_ok_i = 1'b0;
  logic            last_chunk_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            found_o;
  logic [IdxW-1:0] range_first_o;
  logic [IdxW-1:0] range_last_o;

  // Sideband that travels with the word: a typed-in result for table rows.
  bit              row_typed = 1'b0;
  lfrf_res_t       row_word = '0;

  // Scan predictor state.
  logic [LenW-1:0] run_cap;
  logic [IdxW-1:0] next_idx;
  logic            idx_full;
  logic [IdxW-1:0] cur_start;
  logic [LenW-1:0] cur_len;
  logic [IdxW-1:0] best_start;
  logic [LenW-1:0] best_len;
  logic            scan_done;

  lfrf_res_t       pending_runs[$];
  int unsigned     fail_count = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     idle_pct = 0;
  int unsigned     stall_left = 0;

  chunk_row_t directed_rows [23] = '{
    '{1'b0, 32'd0,      1'b1, 1'b1, 1'b1, 1'b1, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b1, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    // equal runs: the earlier one stays best
    '{1'b0, 32'd0,      1'b0, 1'b0, 1'b1, 1'b1, '{1'b1, 16'd0, 16'd1}},
    '{1'b0, 32'd0,      1'b1, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 16'd1, 16'd2}},
    // zero limit acts like one
    '{1'b1, 32'd0,      1'b1, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b1, '{1'b1, 16'd1, 16'd1}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b1, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b1, 32'd2,      1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b1, '{1'b1, 16'd2, 16'd3}},
    '{1'b0, 32'd0,      1'b1, 1'b0, 1'b1, 1'b0, '{1'b0, 16'd0, 16'd0}},
    // early report on the closing word gives one result only
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 16'd0, 16'd1}},
    // limit above any reachable run
    '{1'b1, 32'h1FFFF, 1'b0, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 32'd0,      1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 16'd0, 16'd1}}
  };

  longest_free_run_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .chunk_held_i  (chunk_held_i),
    .web_seed_ok_i (web_seed_ok_i),
    .last_chunk_i  (last_chunk_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .range_first_o (range_first_o),
    .range_last_o  (range_last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    return ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 10);
  endfunction

  // Append an expected result word to the tail of the queue.
  function automatic void add_expected(input lfrf_res_t word);
    pending_runs.insert(pending_runs.size(), word);
  endfunction

  function automatic void clear_scan();
    next_idx   = '0;
    idx_full   = 1'b0;
    cur_start  = '0;
    cur_len    = '0;
    best_start = '0;
    best_len   = '0;
    scan_done  = 1'b0;
  endfunction

  function automatic void close_cur();
    if (cur_len > best_len) begin
      best_start = cur_start;
      best_len   = cur_len;
    end
    cur_start = '0;
    cur_len   = '0;
  endfunction

  function automatic lfrf_res_t run_word(input logic [IdxW-1:0] start,
                                         input logic [LenW-1:0] len);
    lfrf_res_t res;
    res.found       = 1'b1;
    res.range_first = start;
    res.range_last  = IdxW'(start + len - 1'b1);
    return res;
  endfunction

  // Advance the scan by one chunk word; return 1 when it yields a result.
  function automatic bit scan_chunk(input logic held, input logic web,
                                    input logic is_last, output lfrf_res_t res);
    logic            free_now;
    logic [IdxW-1:0] idx;
    bit              emitted;
    emitted = 1'b0;
    res     = '0;
    if (!scan_done) begin
      free_now = !held && web && !idx_full;
      idx      = next_idx;
      if (!idx_full) begin
        if (int'(next_idx) + 1 >= int'(IndexLimit)) idx_full = 1'b1;
        else next_idx = next_idx + 1'b1;
      end
      if (free_now) begin
        if (cur_len == '0) begin
          cur_start = idx;
          cur_len   = LenW'(1);
        end else if (cur_len != '1) begin
          cur_len = cur_len + 1'b1;
        end
        if (cur_len >= run_cap) begin
          res       = run_word(cur_start, cur_len);
          scan_done = 1'b1;
          emitted   = 1'b1;
        end
      end else begin
        close_cur();
      end
      if (is_last && !emitted) begin
        close_cur();
        if (best_len != '0) res = run_word(best_start, best_len);
        emitted = 1'b1;
      end
    end
    if (is_last) clear_scan();
    return emitted;
  endfunction

  // Check results first, then predict: a result never stems from this edge's word.
  always @(posedge clk_i) begin : monitor
    lfrf_res_t want;
    lfrf_res_t calc;
    bit        hit;
    if (!rst_ni) begin
      run_cap = MaxRunReset;
      clear_scan();
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (psel && penable && pready) begin
        quiet_cycles = 0;
        if (pwrite && paddr == MaxRunAddr) run_cap = pwdata[LenW-1:0];
      end
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        if (pending_runs.size() == 0) begin
          $error("unexpected result word: found %0d first %0d last %0d",
                 found_o, range_first_o, range_last_o);
          fail_count++;
        end else begin
          want = pending_runs.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_o);
            fail_count++;
          end
          if (range_first_o !== want.range_first) begin
            $error("range_first: expected %0d, got %0d", want.range_first, range_first_o);
            fail_count++;
          end
          if (range_last_o !== want.range_last) begin
            $error("range_last: expected %0d, got %0d", want.range_last, range_last_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        quiet_cycles = 0;
        hit = scan_chunk(chunk_held_i, web_seed_ok_i, last_chunk_i, calc);
        if (row_typed) add_expected(row_word);
        else if (hit) add_expected(calc);
      end
    end
  end

  // Receiver back-pressure: random bursts; no new burst starts while idle_pct is zero.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left = pick_gap() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_chunk(input logic held, input logic web, input logic is_last,
                            input bit typed, input lfrf_res_t word);
    int unsigned gap;
    gap = (idle_pct != 0 && $urandom_range(99) < idle_pct) ? pick_gap() : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    chunk_held_i  <= held;
    web_seed_ok_i <= web;
    last_chunk_i  <= is_last;
    row_typed     <= typed;
    row_word      <= word;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain, let the block settle, then write the limit and read it back.
  task automatic set_run_cap(input logic [31:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MaxRunAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value[LenW-1:0])) begin
      $error("max_run_length readback: expected %0d, got %0d", value[LenW-1:0], prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_scans(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    int unsigned free_pct;
    int unsigned k;
    logic        held;
    logic        web;
    sent = 0;
    while (sent < items) begin
      len      = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
      free_pct = $urandom_range(95, 30);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(99) < free_pct) begin
          held = 1'b0;
          web  = 1'b1;
        end else begin
          held = 1'($urandom_range(1));
          web  = held ? 1'($urandom_range(1)) : 1'b0;
        end
        send_chunk(held, web, k == len - 1, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("FAIL longest_free_run_finder");
    $finish;
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned p;
    logic [31:0] caps [8];
    caps = '{32'd1, 32'd3, 32'(MaxRunReset), 32'd0, 32'hFFFE_0005, 32'h1_FFFF, 32'd2, 32'd6};
    caps[7] = $urandom_range(12, 1);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    for (i = 0; i < $size(directed_rows); i++) begin
      if (directed_rows[i].set_cap) set_run_cap(directed_rows[i].cap);
      send_chunk(directed_rows[i].held, directed_rows[i].web, directed_rows[i].is_last,
                 directed_rows[i].typed, directed_rows[i].word);
    end

    for (p = 0; p < 8; p++) begin
      set_run_cap(caps[p]);
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
      run_scans(PhaseItems);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) $display("PASS longest_free_run_finder");
    else $display("FAIL longest_free_run_finder");
    $finish;
  end

endmodule
